// File: src/shell_script_feature_scanner_defines.svh
// assertion helpers used by the checker file
`ifndef SHELL_SCRIPT_FEATURE_SCANNER_DEFINES_SVH
`define SHELL_SCRIPT_FEATURE_SCANNER_DEFINES_SVH

// concurrent check, quiet while reset is held
`define SSFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication, quiet while reset is held
`define SSFS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: src/ssfs_pkg.sv
`default_nettype none
package ssfs_pkg;

  // one input beat as it sits in the input register
  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       end_of_script;
  } item_t;

  // the three sticky feature flags
  typedef struct packed {
    logic xtrace;
    logic source;
    logic argv0;
  } flags_t;

  // line phase: leading blanks, a dot after them, rest of the line
  typedef enum logic [1:0] {
    PH_LEAD = 2'd0,
    PH_DOT  = 2'd1,
    PH_REST = 2'd2
  } phase_t;

  localparam int unsigned HIST_DEPTH = 12;
  localparam int unsigned WIN_DEPTH  = HIST_DEPTH + 1;

  // current byte at index 0, older bytes above it
  typedef logic [WIN_DEPTH-1:0][7:0]  window_t;
  typedef logic [HIST_DEPTH-1:0][7:0] hist_t;

  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DOT = 8'h2E;

  // literals packed so that the last character lands at index 0
  localparam window_t LIT_SET_X    = window_t'("set -x");
  localparam window_t LIT_SET_O    = window_t'("set -o xtrace");
  localparam window_t LIT_SOURCE   = window_t'("source ");
  localparam window_t LIT_DOLLAR0  = window_t'("$0");
  localparam window_t LIT_BASH_SRC = window_t'({"${BASH", "_SOURCE"});

  localparam int unsigned LEN_SET_X    = 6;
  localparam int unsigned LEN_SET_O    = 13;
  localparam int unsigned LEN_SOURCE   = 7;
  localparam int unsigned LEN_DOLLAR0  = 2;
  localparam int unsigned LEN_BASH_SRC = 13;

  // true when the first len bytes of the window equal the literal
  function automatic logic lit_match(window_t w, window_t lit, int unsigned len);
    logic hit;
    hit = 1'b1;
    for (int k = 0; k < int'(WIN_DEPTH); k++) begin
      if ((k < int'(len)) && (w[k] != lit[k])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

// File: src/shell_script_feature_scanner.sv
// channel | dir | handshake             | fields
// in      | in  | in_valid / in_ready   | in_text_byte, in_byte_valid, in_end_of_script
// out     | out | out_valid / out_ready | out_found_xtrace, out_found_source, out_found_argv0
//
// one input beat per cycle but for the stall below; a result passes the input register first
// and then the result register; the scan state (history, line phase, flags) updates per beat
// reset is synchronous, active low, and clears handshake and scan state
// beats without an end mark never wait on the output side
// an end-marked beat waits in the input register while the result register is full
`default_nettype none
module shell_script_feature_scanner
  import ssfs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_text_byte,
  input  wire logic       in_byte_valid,
  input  wire logic       in_end_of_script,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_found_xtrace,
  output logic            out_found_source,
  output logic            out_found_argv0
);

  item_t  in_item, s1_item;
  logic   s1_valid, s1_adv, out_free, res_valid;
  flags_t res_flags, out_flags;

  assign in_item.text_byte     = in_text_byte;
  assign in_item.byte_valid    = in_byte_valid;
  assign in_item.end_of_script = in_end_of_script;

  // input register
  ssfs_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s1_adv   (s1_adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // literal match and sticky state
  ssfs_scan_core u_scan_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_item   (s1_item),
    .out_free  (out_free),
    .s1_adv    (s1_adv),
    .res_valid (res_valid),
    .res_flags (res_flags)
  );

  // result register
  ssfs_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_flags (res_flags),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_flags (out_flags)
  );

  assign out_found_xtrace = out_flags.xtrace;
  assign out_found_source = out_flags.source;
  assign out_found_argv0  = out_flags.argv0;

endmodule
`default_nettype wire

// File: src/ssfs_in_stage.sv
`default_nettype none
module ssfs_in_stage
  import ssfs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  s1_adv,
  output logic       s1_valid,
  output item_t      s1_item
);

  logic  s1_valid_r, s1_valid_nxt;
  item_t s1_item_r;
  logic  in_take;

  // room when empty or when the held beat moves on this cycle
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule
`default_nettype wire

// File: src/ssfs_scan_core.sv
`default_nettype none
module ssfs_scan_core
  import ssfs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  s1_valid,
  input  wire item_t s1_item,
  input  wire logic  out_free,
  output logic       s1_adv,
  output logic       res_valid,
  output flags_t     res_flags
);

  hist_t   hist_r, hist_nxt, hist_scan;
  phase_t  phase_r, phase_nxt, phase_scan;
  flags_t  flags_r, flags_nxt, flags_scan, hits;
  window_t win;
  logic [7:0] b;

  assign b   = s1_item.text_byte;
  assign win = {hist_r, b};

  // a beat with an end mark needs the result register, others always move
  assign s1_adv = s1_valid && (!s1_item.end_of_script || out_free);

  // literal comparators over the current byte and the history
  always_comb begin
    hits.xtrace = lit_match(win, LIT_SET_X, LEN_SET_X) ||
                  lit_match(win, LIT_SET_O, LEN_SET_O);
    hits.source = lit_match(win, LIT_SOURCE, LEN_SOURCE) ||
                  ((phase_r == PH_DOT) && (b == CH_SP));
    hits.argv0  = lit_match(win, LIT_DOLLAR0, LEN_DOLLAR0) ||
                  lit_match(win, LIT_BASH_SRC, LEN_BASH_SRC);
  end

  // line phase tracking for the dot-space include
  always_comb begin
    if (b == CH_NL) begin
      phase_scan = PH_LEAD;
    end else begin
      unique case (phase_r)
        PH_LEAD: begin
          if ((b == CH_SP) || (b == CH_TAB)) begin
            phase_scan = PH_LEAD;
          end else if (b == CH_DOT) begin
            phase_scan = PH_DOT;
          end else begin
            phase_scan = PH_REST;
          end
        end
        default: phase_scan = PH_REST;
      endcase
    end
  end

  // state after this beat's byte, if it carries one
  always_comb begin
    if (s1_item.byte_valid) begin
      flags_scan = flags_r | hits;
      hist_scan  = {hist_r[HIST_DEPTH-2:0], b};
    end else begin
      flags_scan = flags_r;
      hist_scan  = hist_r;
    end
  end

  // commit, or report and clear at the end of a script
  always_comb begin
    hist_nxt  = hist_r;
    phase_nxt = phase_r;
    flags_nxt = flags_r;
    res_valid = 1'b0;
    res_flags = flags_scan;
    if (s1_adv) begin
      if (s1_item.end_of_script) begin
        res_valid = 1'b1;
        hist_nxt  = '0;
        phase_nxt = PH_LEAD;
        flags_nxt = '0;
      end else begin
        hist_nxt  = hist_scan;
        flags_nxt = flags_scan;
        if (s1_item.byte_valid) begin
          phase_nxt = phase_scan;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r  <= '0;
      phase_r <= PH_LEAD;
      flags_r <= '0;
    end else begin
      hist_r  <= hist_nxt;
      phase_r <= phase_nxt;
      flags_r <= flags_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/ssfs_out_stage.sv
`default_nettype none
module ssfs_out_stage
  import ssfs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   res_valid,
  input  wire flags_t res_flags,
  output logic        out_free,
  output logic        out_valid,
  input  wire logic   out_ready,
  output flags_t      out_flags
);

  logic   out_valid_r, out_valid_nxt;
  flags_t out_flags_r;

  // register is free when empty or its beat leaves now
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_flags_r <= res_flags;
    end
  end

  assign out_valid = out_valid_r;
  assign out_flags = out_flags_r;

endmodule
`default_nettype wire

// File: src/ssfs_checker.sv
`default_nettype none
`include "shell_script_feature_scanner_defines.svh"
module ssfs_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_end_of_script,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_found_xtrace,
  input wire logic out_found_source,
  input wire logic out_found_argv0
);

  // scripts ended at the input whose results have not left yet
  logic [2:0] pend_r, pend_nxt;
  logic       end_in, res_out;

  assign end_in  = in_valid && in_ready && in_end_of_script;
  assign res_out = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (end_in && !res_out) begin
      pend_nxt = pend_r + 3'd1;
    end else if (!end_in && res_out) begin
      pend_nxt = pend_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // a stalled result beat holds
  `SSFS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_found_xtrace) && $stable(out_found_source) && $stable(out_found_argv0), "result beat dropped or changed under stall")

  // no result without an ended script
  `SSFS_ASSERT_IMP(a_no_extra_result, out_valid, pend_r != 3'd0, "result beat with no ended script")

  // at most one script in the input register and one in the result register
  `SSFS_ASSERT(a_pend_bound, pend_r <= 3'd2, "too many ended scripts in flight")

  // input never stalls while the output side has room
  `SSFS_ASSERT_IMP(a_ready_when_free, !out_valid || out_ready, in_ready, "input stalled with output free")

endmodule

bind shell_script_feature_scanner ssfs_checker u_ssfs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_end_of_script (in_end_of_script),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_found_xtrace (out_found_xtrace),
  .out_found_source (out_found_source),
  .out_found_argv0  (out_found_argv0)
);
`default_nettype wire
